/* sv/isow_pkg.sv */
package isow_pkg;

    localparam int THR_W = 8;
    localparam logic [THR_W-1:0] THR_RESET = 8'd20;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LOAD,
        ST_DIV,
        ST_DONE
    } isow_state_t;

    typedef struct packed {
        logic first;
        logic acc;
        logic load;
        logic step;
    } isow_ctrl_t;

endpackage

/* sv/isow_if.sv */
interface isow_in_if #(
    parameter int ACCEL_BITS = 14,
    parameter int GYRO_BITS  = 8
) ();
    logic                         valid;
    logic                         ready;
    logic signed [ACCEL_BITS-1:0] accel_x;
    logic signed [ACCEL_BITS-1:0] accel_y;
    logic signed [ACCEL_BITS-1:0] accel_z;
    logic signed [GYRO_BITS-1:0]  gyro_x;
    logic signed [GYRO_BITS-1:0]  gyro_y;
    logic signed [GYRO_BITS-1:0]  gyro_z;
    logic                         restart_window;

    modport source (
        output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, restart_window,
        input  ready
    );
    modport sink (
        input  valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, restart_window,
        output ready
    );
endinterface

interface isow_out_if #(
    parameter int ACCEL_BITS = 14,
    parameter int GYRO_BITS  = 8
) ();
    logic                         valid;
    logic                         ready;
    logic                         is_still;
    logic signed [ACCEL_BITS-1:0] accel_offset_x;
    logic signed [ACCEL_BITS-1:0] accel_offset_y;
    logic signed [ACCEL_BITS-1:0] accel_offset_z;
    logic signed [GYRO_BITS-1:0]  gyro_offset_x;
    logic signed [GYRO_BITS-1:0]  gyro_offset_y;
    logic signed [GYRO_BITS-1:0]  gyro_offset_z;

    modport source (
        output valid, is_still, accel_offset_x, accel_offset_y, accel_offset_z,
               gyro_offset_x, gyro_offset_y, gyro_offset_z,
        input  ready
    );
    modport sink (
        input  valid, is_still, accel_offset_x, accel_offset_y, accel_offset_z,
               gyro_offset_x, gyro_offset_y, gyro_offset_z,
        output ready
    );
endinterface

/* sv/isow_cell.sv */
module isow_cell #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= d;
        end
    end

    assign q = data_reg;

endmodule

/* sv/isow_chan.sv */
module isow_chan #(
    parameter int BITS = 8,
    parameter int LEN  = 2
) (
    input  logic                           clk,
    input  isow_pkg::isow_ctrl_t           ctrl,
    input  logic signed [BITS-1:0]         smp,
    input  logic [isow_pkg::THR_W-1:0]     thr,
    output logic                           in_band,
    output logic signed [BITS-1:0]         mean
);

    import isow_pkg::*;

    localparam int RW  = $clog2(LEN);
    localparam int SW  = BITS + RW;
    localparam int KSH = SW + RW;
    // The reciprocal gives the exact quotient for every magnitude below 2**SW.
    localparam longint unsigned RECIP = ((64'd1 << KSH) + 64'(LEN) - 64'd1) / 64'(LEN);
    localparam logic [SW:0] MUL = (SW + 1)'(RECIP);

    logic signed [BITS-1:0] lo_reg;
    logic signed [BITS-1:0] hi_reg;
    logic signed [SW-1:0]   sum_reg;
    logic                   neg_reg;
    logic [SW-1:0]          mag_reg;
    logic [BITS-1:0]        quo_reg;

    logic [SW:0]     sum_ext;
    logic [SW:0]     sum_mag;
    logic [2*SW:0]   prod;
    logic [BITS:0]   spread;

    always_comb
    begin
        sum_ext = {sum_reg[SW-1], sum_reg};
        sum_mag = sum_reg[SW-1] ? (~sum_ext + 1'b1) : sum_ext;
        prod    = mag_reg * MUL;
        spread  = {hi_reg[BITS-1], hi_reg} - {lo_reg[BITS-1], lo_reg};
        in_band = spread <= (BITS + 1)'(thr);
        mean    = neg_reg ? $signed(~quo_reg + 1'b1) : $signed(quo_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.acc)
        begin
            if (ctrl.first)
            begin
                lo_reg  <= smp;
                hi_reg  <= smp;
                sum_reg <= SW'(smp);
            end
            else
            begin
                if (smp < lo_reg)
                begin
                    lo_reg <= smp;
                end
                if (smp > hi_reg)
                begin
                    hi_reg <= smp;
                end
                sum_reg <= sum_reg + SW'(smp);
            end
        end

        if (ctrl.load)
        begin
            neg_reg <= sum_reg[SW-1];
            mag_reg <= sum_mag[SW-1:0];
        end
        else if (ctrl.step)
        begin
            quo_reg <= prod[KSH +: BITS];
        end
    end

endmodule

/* sv/imu_stillness_offset_window.sv */
// IMU stillness detector with offset latch.
// The sample channel takes one IMU sample per transfer: three accelerometer
// axes, three gyro axes and a restart flag that empties the window first.
// The result channel returns one transfer per sample with the still flag and
// the latched per-axis offsets, which change only when a full window is still.
// The window is a row of WINDOW_LENGTH cells; a new sample shifts in at the
// head. When the window is full, the row rotates once around so that every
// entry passes six channel units, which track minimum, maximum and sum, and
// then a reciprocal multiply per channel forms the mean truncated toward zero.
// From its transfer to the earliest result transfer, a sample with a full
// window passes the rotation, the sum magnitude register, the multiply into
// the quotient register and the output register. The next sample can
// transfer in the same cycle as that earliest result transfer. A sample that
// leaves the window short of full goes straight to the output register.
// One sample is in work at a time; the next is taken once the result is in
// the output register, even while that result still waits for the receiver.
// A stalled receiver holds the result and then holds the next sample's
// completion. Reset empties the window, sets the threshold to 20 and clears
// the offsets. The threshold is written through wr_en and wr_data.
module imu_stillness_offset_window #(
    parameter int WINDOW_LENGTH = 50,
    parameter int ACCEL_BITS    = 14,
    parameter int GYRO_BITS     = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [isow_pkg::THR_W-1:0] wr_data,
    isow_in_if.sink                    sample,
    isow_out_if.source                 result
);

    import isow_pkg::*;

    localparam int SMP_W = 3 * ACCEL_BITS + 3 * GYRO_BITS;
    localparam int FW    = $clog2(WINDOW_LENGTH + 1);
    localparam int CW    = $clog2(WINDOW_LENGTH);

    isow_state_t state_reg, state_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [FW-1:0]    fill_reg, fill_next;
    logic             full_reg, full_next;
    logic [THR_W-1:0] thr_reg;
    logic             out_valid_reg, out_valid_next;
    logic             is_still_reg, is_still_next;
    logic signed [ACCEL_BITS-1:0] a_off_reg [3];
    logic signed [ACCEL_BITS-1:0] a_off_next [3];
    logic signed [GYRO_BITS-1:0]  g_off_reg [3];
    logic signed [GYRO_BITS-1:0]  g_off_next [3];

    isow_ctrl_t ctrl;
    logic       in_xfer;
    logic       shift_en;
    logic       still;
    logic [SMP_W-1:0] head_d;
    logic [SMP_W-1:0] tail;
    logic [SMP_W-1:0] chain_q [WINDOW_LENGTH];
    logic [2:0] a_in_band;
    logic [2:0] g_in_band;
    logic signed [ACCEL_BITS-1:0] a_mean [3];
    logic signed [GYRO_BITS-1:0]  g_mean [3];

    assign sample.ready = (state_reg == ST_IDLE);
    assign in_xfer      = sample.valid && sample.ready;
    assign shift_en     = in_xfer || (state_reg == ST_SCAN);
    assign tail         = chain_q[WINDOW_LENGTH-1];
    assign head_d       = (state_reg == ST_IDLE) ?
        {sample.accel_x, sample.accel_y, sample.accel_z,
         sample.gyro_x, sample.gyro_y, sample.gyro_z} : tail;

    for (genvar i = 0; i < WINDOW_LENGTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            isow_cell #(.W(SMP_W)) u_cell (
                .clk (clk),
                .en  (shift_en),
                .d   (head_d),
                .q   (chain_q[i])
            );
        end
        else
        begin : g_body
            isow_cell #(.W(SMP_W)) u_cell (
                .clk (clk),
                .en  (shift_en),
                .d   (chain_q[i-1]),
                .q   (chain_q[i])
            );
        end
    end

    for (genvar c = 0; c < 3; c++)
    begin : g_chan
        isow_chan #(.BITS(ACCEL_BITS), .LEN(WINDOW_LENGTH)) u_accel (
            .clk     (clk),
            .ctrl    (ctrl),
            .smp     ($signed(tail[3*GYRO_BITS + (3-c)*ACCEL_BITS - 1 -: ACCEL_BITS])),
            .thr     (thr_reg),
            .in_band (a_in_band[c]),
            .mean    (a_mean[c])
        );
        isow_chan #(.BITS(GYRO_BITS), .LEN(WINDOW_LENGTH)) u_gyro (
            .clk     (clk),
            .ctrl    (ctrl),
            .smp     ($signed(tail[(3-c)*GYRO_BITS - 1 -: GYRO_BITS])),
            .thr     (thr_reg),
            .in_band (g_in_band[c]),
            .mean    (g_mean[c])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        fill_next      = fill_reg;
        full_next      = full_reg;
        is_still_next  = is_still_reg;
        a_off_next     = a_off_reg;
        g_off_next     = g_off_reg;
        out_valid_next = out_valid_reg && !result.ready;
        ctrl           = '0;
        still          = full_reg && (&a_in_band) && (&g_in_band);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (sample.restart_window)
                    begin
                        fill_next = FW'(1);
                    end
                    else if (fill_reg != FW'(WINDOW_LENGTH))
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                    full_next  = (fill_next == FW'(WINDOW_LENGTH));
                    cnt_next   = '0;
                    state_next = full_next ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN:
            begin
                ctrl.acc   = 1'b1;
                ctrl.first = (cnt_reg == '0);
                if (cnt_reg == CW'(WINDOW_LENGTH - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_LOAD;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_LOAD:
            begin
                ctrl.load  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                ctrl.step  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    is_still_next  = still;
                    if (still)
                    begin
                        a_off_next = a_mean;
                        g_off_next = g_mean;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            fill_reg      <= '0;
            full_reg      <= 1'b0;
            thr_reg       <= THR_RESET;
            out_valid_reg <= 1'b0;
            is_still_reg  <= 1'b0;
            a_off_reg     <= '{default: '0};
            g_off_reg     <= '{default: '0};
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            fill_reg      <= fill_next;
            full_reg      <= full_next;
            out_valid_reg <= out_valid_next;
            is_still_reg  <= is_still_next;
            a_off_reg     <= a_off_next;
            g_off_reg     <= g_off_next;
            if (wr_en)
            begin
                thr_reg <= wr_data;
            end
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.is_still       = is_still_reg;
    assign result.accel_offset_x = a_off_reg[0];
    assign result.accel_offset_y = a_off_reg[1];
    assign result.accel_offset_z = a_off_reg[2];
    assign result.gyro_offset_x  = g_off_reg[0];
    assign result.gyro_offset_y  = g_off_reg[1];
    assign result.gyro_offset_z  = g_off_reg[2];

endmodule
